// ===== design/qts_pkg.sv =====
`default_nettype none

package qts_pkg;

  localparam int unsigned CharWidth = 8;
  localparam int unsigned LenWidth  = 10;

  localparam logic [CharWidth-1:0] ChQuote     = 8'h22;
  localparam logic [CharWidth-1:0] ChBackslash = 8'h5C;
  localparam logic [CharWidth-1:0] ChN         = 8'h6E;
  localparam logic [CharWidth-1:0] ChT         = 8'h74;
  localparam logic [CharWidth-1:0] ChNewline   = 8'h0A;
  localparam logic [CharWidth-1:0] ChTab       = 8'h09;
  localparam logic [CharWidth-1:0] ChSpace     = 8'h20;
  localparam logic [CharWidth-1:0] ChBlankLow  = 8'h09;
  localparam logic [CharWidth-1:0] ChBlankHigh = 8'h0D;

  localparam logic [LenWidth-1:0] MaxLengthReset = 10'd255;

  typedef enum logic [1:0] {
    SCAN_SKIP   = 2'd0,
    SCAN_BARE   = 2'd1,
    SCAN_QUOTED = 2'd2,
    SCAN_ESCAPE = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [CharWidth-1:0] in_byte;
    logic                 at_end;
  } in_item_t;

  typedef struct packed {
    logic [CharWidth-1:0] out_char;
    logic                 token_done;
    logic                 status;
    logic [LenWidth-1:0]  token_length;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/quoted_token_scanner.sv =====
// A byte taken on the input waits in the input register; any result it yields is
// registered in the result register. Throughput: one byte per cycle while out_stall
// does not hold a result; the input register and the result register each take a new
// transfer in the same cycle that the previous one moves on.
// Reset (rst, synchronous, active high) empties both registers, returns the scanner
// to skipping whitespace with a zero character count, and sets max_length to 255.
`default_nettype none

module quoted_token_scanner import qts_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire in_item_t            in_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      out_item_t           out_data,
  input  wire logic                cfg_we,
  input  wire logic [LenWidth-1:0] cfg_wdata
);

  logic [LenWidth-1:0] max_length;
  logic                hold_valid;
  in_item_t            hold;
  scan_mode_t          mode;
  scan_mode_t          mode_next;
  logic [LenWidth-1:0] char_count;
  logic [LenWidth-1:0] char_count_next;
  logic                advance;
  logic                blank;
  logic                full;
  logic                emit;
  logic                finish;
  logic                finish_err;
  logic [CharWidth-1:0] emit_char;
  logic                result;
  out_item_t           result_item;
  logic                slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign advance   = hold_valid && slot_free;
  assign in_stall  = hold_valid && !advance;

  assign blank = (hold.in_byte == ChSpace) ||
                 ((hold.in_byte >= ChBlankLow) && (hold.in_byte <= ChBlankHigh));
  assign full  = char_count >= max_length;

  always_comb begin
    emit       = 1'b0;
    finish     = 1'b0;
    finish_err = 1'b0;
    emit_char  = hold.in_byte;
    case (mode)
      SCAN_SKIP: begin
        if (hold.at_end) begin
          finish     = 1'b1;
          finish_err = 1'b1;
        end else if (!blank && hold.in_byte != ChQuote) begin
          emit = 1'b1;
        end
      end
      SCAN_BARE: begin
        if (hold.at_end || blank) begin
          finish = 1'b1;
        end else if (full) begin
          finish     = 1'b1;
          finish_err = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      SCAN_QUOTED: begin
        if (hold.at_end) begin
          finish     = 1'b1;
          finish_err = 1'b1;
        end else if (hold.in_byte == ChQuote) begin
          finish = 1'b1;
        end else if (full) begin
          finish     = 1'b1;
          finish_err = 1'b1;
        end else if (hold.in_byte != ChBackslash) begin
          emit = 1'b1;
        end
      end
      SCAN_ESCAPE: begin
        if (hold.at_end) begin
          finish     = 1'b1;
          finish_err = 1'b1;
        end else if (hold.in_byte == ChQuote || hold.in_byte == ChBackslash) begin
          emit = 1'b1;
        end else if (hold.in_byte == ChN) begin
          emit      = 1'b1;
          emit_char = ChNewline;
        end else if (hold.in_byte == ChT) begin
          emit      = 1'b1;
          emit_char = ChTab;
        end else begin
          finish     = 1'b1;
          finish_err = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_next = mode;
    if (finish) begin
      mode_next = SCAN_SKIP;
    end else begin
      case (mode)
        SCAN_SKIP: begin
          if (!hold.at_end && !blank) begin
            mode_next = (hold.in_byte == ChQuote) ? SCAN_QUOTED : SCAN_BARE;
          end
        end
        SCAN_QUOTED: begin
          if (!emit) begin
            mode_next = SCAN_ESCAPE;
          end
        end
        SCAN_ESCAPE: begin
          mode_next = SCAN_QUOTED;
        end
        default: begin
          mode_next = mode;
        end
      endcase
    end
  end

  always_comb begin
    result                   = emit || finish;
    char_count_next          = char_count;
    result_item.out_char     = '0;
    result_item.token_done   = 1'b0;
    result_item.status       = 1'b0;
    result_item.token_length = char_count;
    if (finish) begin
      char_count_next          = '0;
      result_item.token_done   = 1'b1;
      result_item.status       = finish_err;
    end else if (emit) begin
      char_count_next          = char_count + LenWidth'(1);
      result_item.out_char     = emit_char;
      result_item.token_length = char_count + LenWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MaxLengthReset;
      hold_valid <= 1'b0;
      mode       <= SCAN_SKIP;
      char_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_length <= cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        mode       <= mode_next;
        char_count <= char_count_next;
      end
      if (advance && result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold <= in_data;
    end
    if (advance && result) begin
      out_data <= result_item;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (mode == SCAN_SKIP && char_count == '0 && !out_valid && !hold_valid))
    else $error("Reset did not clear the scanner state.");

  a_skip_count_zero: assert property (@(posedge clk) disable iff (rst)
    (mode == SCAN_SKIP) |-> (char_count == '0))
    else $error("Character count is nonzero while skipping whitespace.");

  a_char_status_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.token_done) |-> (!out_data.status && out_data.token_length != '0))
    else $error("Character result carries an error or a zero length.");

  a_stall_needs_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (hold_valid && out_valid && out_stall))
    else $error("Input stalled without a blocked result.");

endmodule

`default_nettype wire
